[rtl/core/srle_pkg.sv]
package srle_pkg;

   localparam int unsigned ELEM_W   = 16;
   localparam int unsigned BUDGET_W = 20;
   localparam int unsigned BYTES_W  = 21;
   localparam int unsigned POS_W    = 18;
   localparam int unsigned RUN_W    = 7;
   localparam int unsigned WIDTH_W  = 16;
   localparam int unsigned BPC_W    = 2;

   localparam int unsigned LIT_FLAG_BIT = 7;
   localparam logic [RUN_W-1:0] COUNT_MASK = 7'h7f;

   localparam logic [BPC_W-1:0]   BPC_RESET   = 2'd1;
   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 16'd1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_SHORT   = 2'd1;
   localparam logic [1:0] STATUS_OVERRUN = 2'd2;

   localparam logic [1:0] REG_BPC   = 2'd0;
   localparam logic [1:0] REG_WIDTH = 2'd1;

   typedef enum logic [3:0] {
      PHASE_IDLE = 4'b0001,
      PHASE_CTRL = 4'b0010,
      PHASE_LIT  = 4'b0100,
      PHASE_REP  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic latch;
      logic line_reset;
      logic consume;
      logic load_run;
      logic emit;
      logic set_ctrl;
      logic push_held;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic      line_start;
      phase_type phase;
      logic      cnt_zero;
      logic      run_zero;
      logic      run_last;
      logic      end_reached;
      logic      emit_block;
      logic      out_free;
      logic      held_valid;
      logic      finish_more;
   } sts_type;

endpackage

[rtl/core/srle_ctrl.sv]
module srle_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  srle_pkg::sts_type sts,
   output srle_pkg::cmd_type cmd
);

   typedef enum logic [7:0] {
      ST_WAIT   = 8'b0000_0001,
      ST_START  = 8'b0000_0010,
      ST_LCHK   = 8'b0000_0100,
      ST_EXEC   = 8'b0000_1000,
      ST_RUN    = 8'b0001_0000,
      ST_CHECK  = 8'b0010_0000,
      ST_FLUSH  = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_WAIT);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_WAIT: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_START;
            end
         end
         ST_START: begin
            if (sts.line_start) begin
               cmd.line_reset = 1'b1;
               state_in       = ST_LCHK;
            end else if (sts.phase == srle_pkg::PHASE_IDLE) begin
               state_in = ST_WAIT;
            end else begin
               state_in = ST_EXEC;
            end
         end
         ST_LCHK: begin
            state_in = sts.end_reached ? ST_FINISH : ST_EXEC;
         end
         ST_EXEC: begin
            cmd.consume = 1'b1;
            case (sts.phase)
               srle_pkg::PHASE_CTRL: begin
                  if (sts.cnt_zero) begin
                     state_in = ST_FINISH;
                  end else begin
                     cmd.load_run = 1'b1;
                     state_in     = ST_WAIT;
                  end
               end
               srle_pkg::PHASE_LIT: begin
                  cmd.emit = 1'b1;
                  if (sts.run_last) begin
                     cmd.set_ctrl = 1'b1;
                     state_in     = ST_CHECK;
                  end else begin
                     state_in = ST_FLUSH;
                  end
               end
               srle_pkg::PHASE_REP: state_in = ST_RUN;
               default:             state_in = ST_WAIT;
            endcase
         end
         ST_RUN: begin
            // one repeated sample per cycle while emit_block is low, until the run is used up
            if (sts.run_zero) begin
               cmd.set_ctrl = 1'b1;
               state_in     = ST_CHECK;
            end else if (!sts.emit_block) begin
               cmd.emit = 1'b1;
            end
         end
         ST_CHECK: begin
            state_in = sts.end_reached ? ST_FINISH : ST_FLUSH;
         end
         ST_FLUSH: begin
            if (!sts.held_valid) begin
               state_in = ST_WAIT;
            end else if (sts.out_free) begin
               cmd.push_held = 1'b1;
               state_in      = ST_WAIT;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               if (!sts.finish_more) begin
                  state_in = ST_WAIT;
               end
            end
         end
         default: state_in = ST_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WAIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/srle_datapath.sv]
module srle_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  srle_pkg::cmd_type                   cmd,
   output srle_pkg::sts_type                   sts,
   input  logic [srle_pkg::BPC_W-1:0]          cfg_bpc,
   input  logic [srle_pkg::WIDTH_W-1:0]        cfg_width,
   input  logic [srle_pkg::ELEM_W-1:0]         req_element,
   input  logic                                req_line_start,
   input  logic [srle_pkg::BUDGET_W-1:0]       req_byte_budget,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [srle_pkg::ELEM_W-1:0]         rsp_sample_first,
   output logic [srle_pkg::ELEM_W-1:0]         rsp_sample_second,
   output logic [1:0]                          rsp_sample_count,
   output logic                                rsp_line_done,
   output logic [1:0]                          rsp_line_status
);

   localparam int unsigned EW = srle_pkg::ELEM_W;

   logic                             wide;
   logic [EW-1:0]                    elem_ff, elem_in;
   logic                             start_ff, start_in;
   logic [srle_pkg::BUDGET_W-1:0]    bud_req_ff, bud_req_in;

   srle_pkg::phase_type              phase_ff, phase_in;
   logic [srle_pkg::RUN_W-1:0]       run_ff, run_in;
   logic [srle_pkg::BYTES_W-1:0]     bytes_ff, bytes_in;
   logic [srle_pkg::POS_W-1:0]       pos_ff, pos_in;
   logic [srle_pkg::BUDGET_W-1:0]    budget_ff, budget_in;
   logic [EW-1:0]                    pend_ff, pend_in;
   logic                             pend_valid_ff, pend_valid_in;

   logic [EW-1:0]                    held_a_ff, held_a_in, held_b_ff, held_b_in;
   logic                             held_valid_ff, held_valid_in;

   logic                             out_valid_ff, out_valid_in;
   logic [EW-1:0]                    out_a_ff, out_a_in, out_b_ff, out_b_in;
   logic [1:0]                       out_cnt_ff, out_cnt_in;
   logic                             out_done_ff, out_done_in;
   logic [1:0]                       out_st_ff, out_st_in;

   logic                             in_range;
   logic                             end_now;
   logic                             out_free;
   logic [1:0]                       line_st;
   logic [srle_pkg::POS_W-1:0]       width_ext;

   assign wide      = cfg_bpc[1];
   assign width_ext = {{(srle_pkg::POS_W - srle_pkg::WIDTH_W){1'b0}}, cfg_width};
   assign in_range  = (pos_ff < width_ext);
   assign end_now   = (bytes_ff >= {1'b0, budget_ff}) || (pos_ff >= width_ext);
   assign out_free  = !out_valid_ff || !rsp_stall;

   always_comb begin
      if (pos_ff == width_ext) begin
         line_st = srle_pkg::STATUS_OK;
      end else if (pos_ff < width_ext) begin
         line_st = srle_pkg::STATUS_SHORT;
      end else begin
         line_st = srle_pkg::STATUS_OVERRUN;
      end
   end

   always_comb begin
      sts.line_start  = start_ff;
      sts.phase       = phase_ff;
      sts.cnt_zero    = ((elem_ff[srle_pkg::RUN_W-1:0] & srle_pkg::COUNT_MASK) == '0);
      sts.run_zero    = (run_ff == '0);
      sts.run_last    = (run_ff == srle_pkg::RUN_W'(1));
      sts.end_reached = end_now;
      sts.emit_block  = in_range && pend_valid_ff && held_valid_ff && !out_free;
      sts.out_free    = out_free;
      sts.held_valid  = held_valid_ff;
      sts.finish_more = pend_valid_ff && held_valid_ff;
   end

   always_comb begin
      elem_in       = elem_ff;
      start_in      = start_ff;
      bud_req_in    = bud_req_ff;
      phase_in      = phase_ff;
      run_in        = run_ff;
      bytes_in      = bytes_ff;
      pos_in        = pos_ff;
      budget_in     = budget_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      held_a_in     = held_a_ff;
      held_b_in     = held_b_ff;
      held_valid_in = held_valid_ff;
      out_a_in      = out_a_ff;
      out_b_in      = out_b_ff;
      out_cnt_in    = out_cnt_ff;
      out_done_in   = out_done_ff;
      out_st_in     = out_st_ff;
      out_valid_in  = out_valid_ff && rsp_stall;

      if (cmd.latch) begin
         elem_in    = wide ? req_element : {{(EW - 8){1'b0}}, req_element[7:0]};
         start_in   = req_line_start;
         bud_req_in = req_byte_budget;
      end

      if (cmd.line_reset) begin
         phase_in      = srle_pkg::PHASE_CTRL;
         run_in        = '0;
         bytes_in      = '0;
         pos_in        = '0;
         budget_in     = bud_req_ff;
         pend_in       = '0;
         pend_valid_in = 1'b0;
         held_valid_in = 1'b0;
      end

      if (cmd.consume) begin
         bytes_in = bytes_ff + (wide ? srle_pkg::BYTES_W'(2) : srle_pkg::BYTES_W'(1));
      end

      if (cmd.load_run) begin
         run_in   = elem_ff[srle_pkg::RUN_W-1:0] & srle_pkg::COUNT_MASK;
         phase_in = elem_ff[srle_pkg::LIT_FLAG_BIT] ? srle_pkg::PHASE_LIT
                                                    : srle_pkg::PHASE_REP;
      end

      if (cmd.emit) begin
         if (in_range) begin
            if (pend_valid_ff) begin
               // a finished pair waits in the hold slot until the step is known
               if (held_valid_ff) begin
                  out_valid_in = 1'b1;
                  out_a_in     = held_a_ff;
                  out_b_in     = held_b_ff;
                  out_cnt_in   = 2'd2;
                  out_done_in  = 1'b0;
                  out_st_in    = srle_pkg::STATUS_OK;
               end
               held_a_in     = pend_ff;
               held_b_in     = elem_ff;
               held_valid_in = 1'b1;
               pend_in       = '0;
               pend_valid_in = 1'b0;
            end else begin
               pend_in       = elem_ff;
               pend_valid_in = 1'b1;
            end
         end
         pos_in = pos_ff + srle_pkg::POS_W'(1);
         if (run_ff != '0) begin
            run_in = run_ff - srle_pkg::RUN_W'(1);
         end
      end

      if (cmd.set_ctrl) begin
         phase_in = srle_pkg::PHASE_CTRL;
      end

      if (cmd.push_held) begin
         out_valid_in  = 1'b1;
         out_a_in      = held_a_ff;
         out_b_in      = held_b_ff;
         out_cnt_in    = 2'd2;
         out_done_in   = 1'b0;
         out_st_in     = srle_pkg::STATUS_OK;
         held_valid_in = 1'b0;
      end

      if (cmd.finish) begin
         out_valid_in = 1'b1;
         if (pend_valid_ff && held_valid_ff) begin
            out_a_in      = held_a_ff;
            out_b_in      = held_b_ff;
            out_cnt_in    = 2'd2;
            out_done_in   = 1'b0;
            out_st_in     = srle_pkg::STATUS_OK;
            held_valid_in = 1'b0;
         end else begin
            if (pend_valid_ff) begin
               out_a_in   = pend_ff;
               out_b_in   = '0;
               out_cnt_in = 2'd1;
            end else if (held_valid_ff) begin
               out_a_in   = held_a_ff;
               out_b_in   = held_b_ff;
               out_cnt_in = 2'd2;
            end else begin
               out_a_in   = '0;
               out_b_in   = '0;
               out_cnt_in = 2'd0;
            end
            out_done_in   = 1'b1;
            out_st_in     = line_st;
            held_valid_in = 1'b0;
            pend_in       = '0;
            pend_valid_in = 1'b0;
            run_in        = '0;
            phase_in      = srle_pkg::PHASE_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= srle_pkg::PHASE_IDLE;
         run_ff        <= '0;
         bytes_ff      <= '0;
         pos_ff        <= '0;
         budget_ff     <= '0;
         pend_ff       <= '0;
         pend_valid_ff <= 1'b0;
         held_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         start_ff      <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         run_ff        <= run_in;
         bytes_ff      <= bytes_in;
         pos_ff        <= pos_in;
         budget_ff     <= budget_in;
         pend_ff       <= pend_in;
         pend_valid_ff <= pend_valid_in;
         held_valid_ff <= held_valid_in;
         out_valid_ff  <= out_valid_in;
         start_ff      <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      elem_ff     <= elem_in;
      bud_req_ff  <= bud_req_in;
      held_a_ff   <= held_a_in;
      held_b_ff   <= held_b_in;
      out_a_ff    <= out_a_in;
      out_b_ff    <= out_b_in;
      out_cnt_ff  <= out_cnt_in;
      out_done_ff <= out_done_in;
      out_st_ff   <= out_st_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_sample_first  = out_a_ff;
   assign rsp_sample_second = out_b_ff;
   assign rsp_sample_count  = out_cnt_ff;
   assign rsp_line_done     = out_done_ff;
   assign rsp_line_status   = out_st_ff;

endmodule

[rtl/core/sgi_rle_scanline_decoder.sv]
// Run-length scanline decoder: one stream element (byte or big-endian word, set by
// bytes_per_channel) per accepted item, decoded samples out in pairs, with line_done and
// an ok/short/overrun status on the last result of each line. One item is worked at a
// time, and no new item is accepted until the last one is through; the datapath's emit
// step places one sample per cycle and each finished pair passes through a single hold
// slot and a single output register (a stalled output holds the run).
// Registers sit at byte address 0 (bytes_per_channel) and 4 (line_width); the user must
// see that they are written only while the decoder is idle, as the block itself does not
// enforce it; pready is always high.
module sgi_rle_scanline_decoder (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [srle_pkg::ELEM_W-1:0]        req_element,
   input  logic                               req_line_start,
   input  logic [srle_pkg::BUDGET_W-1:0]      req_byte_budget,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [srle_pkg::ELEM_W-1:0]        rsp_sample_first,
   output logic [srle_pkg::ELEM_W-1:0]        rsp_sample_second,
   output logic [1:0]                         rsp_sample_count,
   output logic                               rsp_line_done,
   output logic [1:0]                         rsp_line_status,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [2:0]                         csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   logic [srle_pkg::BPC_W-1:0]   bpc_ff, bpc_in;
   logic [srle_pkg::WIDTH_W-1:0] width_ff, width_in;
   logic                         csr_write;
   logic [1:0]                   reg_index;

   srle_pkg::cmd_type            cmd;
   srle_pkg::sts_type            sts;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = {1'b0, csr_paddr[2]};

   always_comb begin
      bpc_in   = bpc_ff;
      width_in = width_ff;
      if (csr_write) begin
         case (reg_index)
            srle_pkg::REG_BPC:   bpc_in   = csr_pwdata[srle_pkg::BPC_W-1:0];
            srle_pkg::REG_WIDTH: width_in = csr_pwdata[srle_pkg::WIDTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         srle_pkg::REG_BPC:   csr_prdata = {{(32 - srle_pkg::BPC_W){1'b0}}, bpc_ff};
         srle_pkg::REG_WIDTH: csr_prdata = {{(32 - srle_pkg::WIDTH_W){1'b0}}, width_ff};
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpc_ff   <= srle_pkg::BPC_RESET;
         width_ff <= srle_pkg::WIDTH_RESET;
      end else begin
         bpc_ff   <= bpc_in;
         width_ff <= width_in;
      end
   end

   srle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   srle_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .cfg_bpc           (bpc_ff),
      .cfg_width         (width_ff),
      .req_element       (req_element),
      .req_line_start    (req_line_start),
      .req_byte_budget   (req_byte_budget),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sample_first  (rsp_sample_first),
      .rsp_sample_second (rsp_sample_second),
      .rsp_sample_count  (rsp_sample_count),
      .rsp_line_done     (rsp_line_done),
      .rsp_line_status   (rsp_line_status)
   );

endmodule

[dv/srle_checker.sv]
`timescale 1ns / 1ps
module srle_checker
   import srle_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [ELEM_W-1:0]   req_element,
   input  logic                req_line_start,
   input  logic [BUDGET_W-1:0] req_byte_budget,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [ELEM_W-1:0]   rsp_sample_first,
   input  logic [ELEM_W-1:0]   rsp_sample_second,
   input  logic [1:0]          rsp_sample_count,
   input  logic                rsp_line_done,
   input  logic [1:0]          rsp_line_status,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   input  logic                csr_pready,
   output int unsigned         mismatch_count,
   output int unsigned         results_due
);

   typedef struct packed {
      logic [ELEM_W-1:0] first;
      logic [ELEM_W-1:0] second;
      logic [1:0]        count;
      logic              done;
      logic [1:0]        status;
   } sample_pair_type;

   sample_pair_type pairs_due[$];
   sample_pair_type step_pairs[$];

   logic [BPC_W-1:0]    cfg_bpc;
   logic [WIDTH_W-1:0]  cfg_width;
   phase_type           line_phase;
   logic [RUN_W-1:0]    run_count;
   logic [BYTES_W-1:0]  consumed_bytes;
   logic [POS_W-1:0]    pixel_pos;
   logic [BUDGET_W-1:0] line_budget;
   logic [ELEM_W-1:0]   held_sample;
   logic                held_valid;
   int unsigned         miss_total = 0;

   function automatic logic line_over();
      return consumed_bytes >= line_budget || pixel_pos >= cfg_width;
   endfunction

   // samples past the line width are dropped but still advance the position
   task automatic place_sample(input logic [ELEM_W-1:0] s);
      if (pixel_pos < cfg_width) begin
         if (held_valid) begin
            step_pairs.push_back('{held_sample, s, 2'd2, 1'b0, STATUS_OK});
            held_valid = 1'b0;
            held_sample = '0;
         end else begin
            held_sample = s;
            held_valid = 1'b1;
         end
      end
      pixel_pos = pixel_pos + 1'b1;
   endtask

   task automatic close_line();
      logic [1:0]      st;
      sample_pair_type tail;
      if (pixel_pos == cfg_width) begin
         st = STATUS_OK;
      end else if (pixel_pos < cfg_width) begin
         st = STATUS_SHORT;
      end else begin
         st = STATUS_OVERRUN;
      end
      if (held_valid) begin
         step_pairs.push_back('{held_sample, 16'h0000, 2'd1, 1'b1, st});
      end else if (step_pairs.size() > 0) begin
         // no odd sample left: the last pair of this item carries the line end
         tail = step_pairs.pop_back();
         tail.done = 1'b1;
         tail.status = st;
         step_pairs.push_back(tail);
      end else begin
         step_pairs.push_back('{16'h0000, 16'h0000, 2'd0, 1'b1, st});
      end
      held_valid = 1'b0;
      held_sample = '0;
      run_count = '0;
      line_phase = PHASE_IDLE;
   endtask

   task automatic predict_item(input logic [ELEM_W-1:0] raw, input logic start,
                               input logic [BUDGET_W-1:0] bud);
      logic              wide;
      logic              ended;
      logic [ELEM_W-1:0] elem;
      wide = cfg_bpc[1];
      elem = wide ? raw : {8'h00, raw[7:0]};
      ended = 1'b0;
      step_pairs.delete();
      if (start) begin
         // a new line drops whatever the old one still held
         line_phase = PHASE_CTRL;
         run_count = '0;
         consumed_bytes = '0;
         pixel_pos = '0;
         line_budget = bud;
         held_sample = '0;
         held_valid = 1'b0;
         if (line_over()) begin
            close_line();
            ended = 1'b1;
         end
      end
      if (!ended && line_phase != PHASE_IDLE) begin
         consumed_bytes = consumed_bytes + (wide ? BYTES_W'(2) : BYTES_W'(1));
         case (line_phase)
            PHASE_CTRL: begin
               if ((elem[RUN_W-1:0] & COUNT_MASK) == '0) begin
                  close_line();
               end else begin
                  run_count = elem[RUN_W-1:0] & COUNT_MASK;
                  line_phase = elem[LIT_FLAG_BIT] ? PHASE_LIT : PHASE_REP;
               end
            end
            PHASE_LIT: begin
               place_sample(elem);
               if (run_count > 0) run_count = run_count - 1'b1;
               if (run_count == 0) begin
                  line_phase = PHASE_CTRL;
                  if (line_over()) close_line();
               end
            end
            PHASE_REP: begin
               while (run_count > 0) begin
                  place_sample(elem);
                  run_count = run_count - 1'b1;
               end
               line_phase = PHASE_CTRL;
               if (line_over()) close_line();
            end
            default: ;
         endcase
      end
      foreach (step_pairs[i]) pairs_due.push_back(step_pairs[i]);
   endtask

   task automatic check_pair();
      sample_pair_type got;
      sample_pair_type want;
      got = '{rsp_sample_first, rsp_sample_second, rsp_sample_count, rsp_line_done,
              rsp_line_status};
      if (pairs_due.size() == 0) begin
         miss_total++;
         if (miss_total <= 10)
            $display("%0t: unexpected result first=%h second=%h count=%0d done=%b status=%0d",
                     $time, got.first, got.second, got.count, got.done, got.status);
      end else begin
         want = pairs_due.pop_front();
         if (got.first !== want.first || got.second !== want.second ||
             got.count !== want.count || got.done !== want.done ||
             got.status !== want.status) begin
            miss_total++;
            if (miss_total <= 10) begin
               $display("%0t: mismatch expected first=%h second=%h count=%0d done=%b status=%0d",
                        $time, want.first, want.second, want.count, want.done, want.status);
               $display("%0t:               got first=%h second=%h count=%0d done=%b status=%0d",
                        $time, got.first, got.second, got.count, got.done, got.status);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_bpc = BPC_RESET;
         cfg_width = WIDTH_RESET;
         line_phase = PHASE_IDLE;
         run_count = '0;
         consumed_bytes = '0;
         pixel_pos = '0;
         line_budget = '0;
         held_sample = '0;
         held_valid = 1'b0;
         pairs_due.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr >> 2)
               REG_BPC:   cfg_bpc = csr_pwdata[BPC_W-1:0];
               REG_WIDTH: cfg_width = csr_pwdata[WIDTH_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            predict_item(req_element, req_line_start, req_byte_budget);
         if (rsp_valid && !rsp_stall)
            check_pair();
      end
      mismatch_count <= miss_total;
      results_due <= pairs_due.size();
   end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
module tb;
   import srle_pkg::*;

   localparam int unsigned CYCLE_LIMIT    = 1000000;
   localparam int unsigned DRAIN_CYCLES   = 200;
   localparam int unsigned HOLDOFF_CYCLES = 400;
   localparam int unsigned PHASE_ITEMS    = 35;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [ELEM_W-1:0]   req_element = '0;
   logic                req_line_start = 1'b0;
   logic [BUDGET_W-1:0] req_byte_budget = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [ELEM_W-1:0]   rsp_sample_first;
   logic [ELEM_W-1:0]   rsp_sample_second;
   logic [1:0]          rsp_sample_count;
   logic                rsp_line_done;
   logic [1:0]          rsp_line_status;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [2:0]          csr_paddr = '0;
   logic [31:0]         csr_pwdata = '0;
   logic [31:0]         csr_prdata;
   logic                csr_pready;
   int unsigned         mismatch_count;
   int unsigned         results_due;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned cycle_count = 0;
   int unsigned items_sent = 0;
   int unsigned holdoff_left = 0;
   bit          holdoff_go = 1'b0;
   int unsigned cur_width = 1;

   sgi_rle_scanline_decoder i_dut (.*);
   srle_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // receiver: random stall, or one long hold-off when asked
   always @(posedge clock) begin
      if (holdoff_go) begin
         holdoff_go = 1'b0;
         holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic logic [ELEM_W-1:0] ctrl_word(input logic lit, input int unsigned n);
      return {8'($urandom), lit, 7'(n)};
   endfunction

   task automatic send_item(input logic [ELEM_W-1:0] e, input logic start,
                            input logic [BUDGET_W-1:0] bud);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_element <= e;
      req_line_start <= start;
      req_byte_budget <= bud;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] keep;
      keep = (idx == REG_BPC) ? 32'h3 : 32'hffff;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 3'(idx) << 2;
      csr_pwdata <= ($urandom & ~keep) | (value & keep);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [1:0] bpc, input int unsigned width);
      wait_drained();
      // a run of dropped samples gives no result but keeps the block busy
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write(REG_BPC, bpc);
      csr_write(REG_WIDTH, width);
      cur_width = width;
   endtask

   task automatic send_line();
      logic [BUDGET_W-1:0] bud;
      logic                lit;
      logic                broken;
      int unsigned         n;
      int unsigned         m;
      int unsigned         placed;
      int unsigned         goal;
      int unsigned         pkt;
      case ($urandom_range(9))
         0:       bud = 20'($urandom);
         1:       bud = 20'($urandom_range(0, 3));
         default: bud = 20'($urandom_range(4, 200));
      endcase
      broken = ($urandom_range(9) == 0);
      goal = cur_width + $urandom_range(0, 2);
      placed = 0;
      pkt = 0;
      while ((pkt == 0 || placed < goal) && pkt < 8) begin
         lit = $urandom_range(1);
         n = ($urandom_range(19) == 0) ? $urandom_range(9, 127) : $urandom_range(1, 8);
         send_item(ctrl_word(lit, n), pkt == 0, pkt == 0 ? bud : 20'($urandom));
         if (lit) begin
            m = broken ? $urandom_range(0, n - 1) : n;
            for (int k = 0; k < m; k++) send_item(16'($urandom), 1'b0, 20'($urandom));
            if (broken) return;
         end else begin
            send_item(16'($urandom), 1'b0, 20'($urandom));
         end
         placed += n;
         pkt++;
      end
      if (!broken && $urandom_range(3) != 0)
         send_item(ctrl_word($urandom_range(1), 0), 1'b0, 20'($urandom));
   endtask

   initial begin
      logic [1:0]  bpc_set[8];
      int unsigned width_set[8];
      int unsigned goal;
      bpc_set = '{2'd1, 2'd2, 2'd0, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0};
      width_set = '{16, 7, 33, 3, 100, 65535, 1, 2};
      width_set[7] = $urandom_range(1, 65535);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // one-byte mode through the odd width code, short line of four pixels
      configure(2'd0, 4);
      send_item(16'h1234, 1'b0, 20'd0);          // outside a line: ignored
      send_item(16'h0005, 1'b1, 20'd0);          // zero budget ends at once
      send_item(16'hab82, 1'b1, 20'd100);        // literal run of two
      send_item(16'h55ff, 1'b0, 20'd0);
      send_item(16'h0000, 1'b0, 20'd0);
      send_item(16'hff03, 1'b0, 20'd0);          // repeat crosses the width
      send_item(16'h005a, 1'b0, 20'd0);
      send_item(16'h0081, 1'b1, 20'hfffff);
      send_item(16'h0011, 1'b0, 20'd0);
      send_item(16'h0084, 1'b1, 20'd3);          // restart drops the held sample
      send_item(16'h0001, 1'b0, 20'd0);
      send_item(16'h0002, 1'b0, 20'd0);
      send_item(16'h0003, 1'b0, 20'd0);
      send_item(16'h0004, 1'b0, 20'd0);
      send_item(16'h0000, 1'b1, 20'd9);          // zero count as first control
      send_item(16'h007f, 1'b1, 20'd50);         // longest repeat
      send_item(16'h00c3, 1'b0, 20'd0);
      send_item(16'h0081, 1'b1, 20'd2);          // budget runs out with odd sample
      send_item(16'h0077, 1'b0, 20'd0);
      configure(2'd3, 0);
      send_item(16'h0281, 1'b1, 20'd10);         // zero width: done, ok
      configure(2'd2, 65535);
      send_item(16'hff82, 1'b1, 20'hfffff);
      send_item(16'hffff, 1'b0, 20'd0);
      send_item(16'h0000, 1'b0, 20'd0);
      send_item(16'h7f7f, 1'b0, 20'd0);
      send_item(16'h8001, 1'b0, 20'd0);
      send_item(16'hff00, 1'b0, 20'd0);

      for (int ph = 0; ph < 8; ph++) begin
         configure(bpc_set[ph], width_set[ph]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 50; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 50; end
            default: begin send_idle_pct = 6; stall_pct = 6; end
         endcase
         if (ph == 4) holdoff_go = 1'b1;
         goal = items_sent + PHASE_ITEMS;
         while (items_sent < goal) begin
            if ($urandom_range(9) == 0) begin
               send_item(16'($urandom), $urandom_range(3) == 0, 20'($urandom_range(0, 300)));
            end else begin
               send_line();
            end
            if ($urandom_range(29) == 0) wait_drained();
         end
         // close any open line so the registers change with the block idle
         send_item(ctrl_word(1'b0, 1), 1'b1, 20'd0);
         send_idle_pct = 0;
         stall_pct = 0;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && results_due == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
